@@ hdl/frame_time_and_rate_statistics_top_assert.svh @@
// Assertion macros for the frame time and rate statistics block.
// Needs i_clk and i_rst_n in the including module's scope.
`ifndef FRAME_TIME_AND_RATE_STATISTICS_TOP_ASSERT_SVH
`define FRAME_TIME_AND_RATE_STATISTICS_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FTRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define FTRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ftrs_pkg.sv @@
// Shared types and constants of the frame time and rate statistics block.
// No dependencies.
package ftrs_pkg;

    localparam int TIME_US_W  = 48;
    localparam int TIME_MS_W  = 32;
    localparam int MEM_W      = 24;
    localparam int STACK_W    = 16;
    localparam int DUR_W      = 32;
    localparam int SUM_W      = 64;
    localparam int CNT_W      = 32;
    localparam int RATE_W     = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int ACTION_W   = 2;
    localparam int RATE_NUM_W = 42;
    localparam int MS_PER_S   = 1000;

    localparam logic [CFG_W-1:0] FPS_WINDOW_RST    = 16'd1000;
    localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST = 16'd60;

    localparam logic [CFG_IDX_W-1:0] REG_FPS_WINDOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_BEGIN = 2'd0,
        ACT_END   = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ACC,
        S_START,
        S_DIV,
        S_WB,
        S_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic do_exec;
        logic do_acc;
        logic div_start;
        logic do_wb;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_frame_end;
        logic div_busy;
        logic out_free;
    } t_dp_status;

endpackage

@@ hdl/ftrs_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Stand-alone; no package needed.
module ftrs_div #(
    parameter int P_N_W = 64,
    parameter int P_D_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [P_N_W-1:0] i_dividend,
    input  logic [P_D_W-1:0] i_divisor,
    output logic [P_N_W-1:0] o_quotient,
    output logic             o_busy
);
    localparam int CW = $clog2(P_N_W + 1);

    logic [P_N_W-1:0] r_quot;
    logic [P_D_W-1:0] r_rem;
    logic [P_D_W-1:0] r_div;
    logic [CW-1:0]    r_cnt;

    logic [P_D_W:0] w_trial;
    logic [P_D_W:0] w_diff;
    logic           w_ge;

    assign w_trial = {r_rem, r_quot[P_N_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(P_N_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quot <= {r_quot[P_N_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[P_D_W-1:0] : w_trial[P_D_W-1:0];
        end
    end

    assign o_quotient = r_quot;
    assign o_busy     = (r_cnt != '0);

endmodule

@@ hdl/ftrs_dp.sv @@
// Datapath: statistics state, configuration registers, dividers, result beat.
// Uses ftrs_pkg and ftrs_div.
module ftrs_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ftrs_pkg::t_dp_cmd                 i_cmd,
    output ftrs_pkg::t_dp_status              o_status,
    input  logic                              i_cfg_valid,
    input  logic [ftrs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ftrs_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic [ftrs_pkg::ACTION_W-1:0]     i_action,
    input  logic [ftrs_pkg::TIME_US_W-1:0]    i_time_us,
    input  logic [ftrs_pkg::TIME_MS_W-1:0]    i_time_ms,
    input  logic [ftrs_pkg::MEM_W-1:0]        i_free_mem_bytes,
    input  logic [ftrs_pkg::STACK_W-1:0]      i_stack_headroom_words,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic [ftrs_pkg::RATE_W-1:0]       o_frames_per_second,
    output logic [ftrs_pkg::DUR_W-1:0]        o_mean_frame_us,
    output logic [ftrs_pkg::DUR_W-1:0]        o_min_frame_us,
    output logic [ftrs_pkg::DUR_W-1:0]        o_max_frame_us,
    output logic [ftrs_pkg::CNT_W-1:0]        o_frames_seen,
    output logic [ftrs_pkg::MEM_W-1:0]        o_mem_free_bytes,
    output logic [ftrs_pkg::MEM_W-1:0]        o_mem_low_bytes,
    output logic [ftrs_pkg::STACK_W-1:0]      o_stack_words,
    output logic [ftrs_pkg::TIME_MS_W-1:0]    o_uptime_ms
);
    import ftrs_pkg::*;

    // configuration
    logic [CFG_W-1:0] r_cfg_fps;
    logic [CFG_W-1:0] r_cfg_period;

    // captured beat
    logic [ACTION_W-1:0]  r_action;
    logic [TIME_US_W-1:0] r_time_us;
    logic [TIME_MS_W-1:0] r_time_ms;
    logic [MEM_W-1:0]     r_free_mem;
    logic [STACK_W-1:0]   r_stack;

    // statistics state
    logic [TIME_US_W-1:0] r_begin;
    logic [CNT_W-1:0]     r_frame_total;
    logic [SUM_W-1:0]     r_sum;
    logic [DUR_W-1:0]     r_shortest;
    logic [DUR_W-1:0]     r_longest;
    logic [DUR_W-1:0]     r_mean;
    logic [CNT_W-1:0]     r_win_frames;
    logic [TIME_MS_W-1:0] r_win_start;
    logic [RATE_W-1:0]    r_rate;
    logic [CFG_W-1:0]     r_sample_cnt;
    logic [MEM_W-1:0]     r_mem_last;
    logic [MEM_W-1:0]     r_mem_lowest;
    logic [STACK_W-1:0]   r_stack_last;

    // intermediate frame-end values
    logic [DUR_W-1:0]      r_dur;
    logic [TIME_MS_W-1:0]  r_elapsed;
    logic                  r_rate_due;
    logic [CNT_W-1:0]      r_wf_snap;
    logic [RATE_NUM_W-1:0] r_rate_num;

    // result beat
    logic                 r_out_valid;
    logic [RATE_W-1:0]    r_out_fps;
    logic [DUR_W-1:0]     r_out_mean;
    logic [DUR_W-1:0]     r_out_min;
    logic [DUR_W-1:0]     r_out_max;
    logic [CNT_W-1:0]     r_out_frames;
    logic [MEM_W-1:0]     r_out_mem_free;
    logic [MEM_W-1:0]     r_out_mem_low;
    logic [STACK_W-1:0]   r_out_stack;
    logic [TIME_MS_W-1:0] r_out_uptime;

    logic [TIME_US_W-1:0]  w_us_diff;
    logic [DUR_W-1:0]      w_dur;
    logic [TIME_MS_W-1:0]  w_ws_eff;
    logic [TIME_MS_W-1:0]  w_elapsed;
    logic [CFG_W-1:0]      w_win;
    logic                  w_due;
    logic [CNT_W-1:0]      w_wf_inc;
    logic [CFG_W-1:0]      w_sc_inc;
    logic                  w_sample;
    logic [CNT_W-1:0]      w_total_inc;
    logic [SUM_W-1:0]      w_sum_new;
    logic [SUM_W-1:0]      w_mean_quot;
    logic [RATE_NUM_W-1:0] w_rate_quot;
    logic                  w_mean_busy;
    logic                  w_rate_busy;
    logic                  w_out_free;

    assign w_us_diff   = r_time_us - r_begin;
    assign w_dur       = (r_time_us > r_begin) ? w_us_diff[DUR_W-1:0] : '0;
    assign w_ws_eff    = (r_win_start == '0) ? r_time_ms : r_win_start;
    assign w_elapsed   = r_time_ms - w_ws_eff;
    assign w_win       = (r_cfg_fps == '0) ? CFG_W'(1) : r_cfg_fps;
    assign w_due       = w_elapsed >= TIME_MS_W'(w_win);
    assign w_wf_inc    = r_win_frames + 1'b1;
    assign w_sc_inc    = r_sample_cnt + 1'b1;
    assign w_sample    = w_sc_inc >= r_cfg_period;
    assign w_total_inc = r_frame_total + 1'b1;
    assign w_sum_new   = r_sum + SUM_W'(r_dur);
    assign w_out_free  = !r_out_valid || !i_stall;

    ftrs_div #(
        .P_N_W (SUM_W),
        .P_D_W (CNT_W)
    ) u_mean_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_frame_total),
        .o_quotient (w_mean_quot),
        .o_busy     (w_mean_busy)
    );

    ftrs_div #(
        .P_N_W (RATE_NUM_W),
        .P_D_W (TIME_MS_W)
    ) u_rate_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rate_num),
        .i_divisor  (r_elapsed),
        .o_quotient (w_rate_quot),
        .o_busy     (w_rate_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_fps     <= FPS_WINDOW_RST;
            r_cfg_period  <= SAMPLE_PERIOD_RST;
            r_begin       <= '0;
            r_frame_total <= '0;
            r_sum         <= '0;
            r_shortest    <= '1;
            r_longest     <= '0;
            r_mean        <= '0;
            r_win_frames  <= '0;
            r_win_start   <= '0;
            r_rate        <= '0;
            r_sample_cnt  <= '0;
            r_mem_last    <= '0;
            r_mem_lowest  <= '1;
            r_stack_last  <= '0;
            r_rate_due    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_FPS_WINDOW:    r_cfg_fps    <= i_cfg_data;
                    REG_SAMPLE_PERIOD: r_cfg_period <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.do_exec) begin
                case (r_action)
                    ACT_BEGIN: begin
                        r_begin <= r_time_us;
                    end
                    ACT_END: begin
                        r_wf_snap  <= w_wf_inc;
                        r_rate_due <= w_due;
                        r_elapsed  <= w_elapsed;
                        if (w_due) begin
                            r_win_frames <= '0;
                            r_win_start  <= r_time_ms;
                        end else begin
                            r_win_frames <= w_wf_inc;
                            r_win_start  <= w_ws_eff;
                        end
                        if (w_sample) begin
                            r_sample_cnt <= '0;
                            r_mem_last   <= r_free_mem;
                            if (r_free_mem < r_mem_lowest) begin
                                r_mem_lowest <= r_free_mem;
                            end
                        end else begin
                            r_sample_cnt <= w_sc_inc;
                            if (w_sc_inc == CFG_W'(1)) begin
                                r_stack_last <= r_stack;
                            end
                        end
                    end
                    ACT_CLEAR: begin
                        r_shortest    <= '1;
                        r_longest     <= '0;
                        r_sum         <= '0;
                        r_mean        <= '0;
                        r_frame_total <= '0;
                        r_win_frames  <= '0;
                        r_win_start   <= '0;
                        r_rate        <= '0;
                        r_mem_lowest  <= r_mem_last;
                    end
                    default: ;
                endcase
            end

            if (i_cmd.do_acc) begin
                r_frame_total <= w_total_inc;
                r_sum         <= w_sum_new;
                if (r_dur < r_shortest) begin
                    r_shortest <= r_dur;
                end
                if (r_dur > r_longest) begin
                    r_longest <= r_dur;
                end
            end

            if (i_cmd.do_wb) begin
                if (r_frame_total != '0) begin
                    r_mean <= w_mean_quot[DUR_W-1:0];
                end
                if (r_rate_due) begin
                    r_rate <= (|w_rate_quot[RATE_NUM_W-1:RATE_W]) ? '1
                                                                 : w_rate_quot[RATE_W-1:0];
                end
            end

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action   <= i_action;
            r_time_us  <= i_time_us;
            r_time_ms  <= i_time_ms;
            r_free_mem <= i_free_mem_bytes;
            r_stack    <= i_stack_headroom_words;
        end
        if (i_cmd.do_exec) begin
            r_dur <= w_dur;
        end
        if (i_cmd.do_acc) begin
            r_rate_num <= RATE_NUM_W'(r_wf_snap) * RATE_NUM_W'(MS_PER_S);
        end
        if (i_cmd.load_out) begin
            r_out_fps      <= r_rate;
            r_out_mean     <= r_mean;
            r_out_min      <= (r_shortest == '1) ? '0 : r_shortest;
            r_out_max      <= r_longest;
            r_out_frames   <= r_frame_total;
            r_out_mem_free <= r_mem_last;
            r_out_mem_low  <= (r_mem_lowest == '1) ? '0 : r_mem_lowest;
            r_out_stack    <= r_stack_last;
            r_out_uptime   <= r_time_ms;
        end
    end

    assign o_status.is_frame_end = (r_action == ACT_END);
    assign o_status.div_busy     = w_mean_busy || w_rate_busy;
    assign o_status.out_free     = w_out_free;

    assign o_valid             = r_out_valid;
    assign o_frames_per_second = r_out_fps;
    assign o_mean_frame_us     = r_out_mean;
    assign o_min_frame_us      = r_out_min;
    assign o_max_frame_us      = r_out_max;
    assign o_frames_seen       = r_out_frames;
    assign o_mem_free_bytes    = r_out_mem_free;
    assign o_mem_low_bytes     = r_out_mem_low;
    assign o_stack_words       = r_out_stack;
    assign o_uptime_ms         = r_out_uptime;

endmodule

@@ hdl/ftrs_ctrl.sv @@
// Controller state machine sequencing one beat through the datapath.
// Uses ftrs_pkg.
module ftrs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  ftrs_pkg::t_dp_status i_status,
    output ftrs_pkg::t_dp_cmd    o_cmd
);
    import ftrs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_EXEC;
            S_EXEC:  n_state = i_status.is_frame_end ? S_ACC : S_OUT;
            S_ACC:   n_state = S_START;
            S_START: n_state = S_DIV;
            S_DIV:   if (!i_status.div_busy) n_state = S_WB;
            S_WB:    n_state = S_OUT;
            S_OUT:   if (i_status.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.capture = i_valid;
            end
            S_EXEC:  o_cmd.do_exec   = 1'b1;
            S_ACC:   o_cmd.do_acc    = 1'b1;
            S_START: o_cmd.div_start = 1'b1;
            S_DIV:   ;
            S_WB:    o_cmd.do_wb     = 1'b1;
            S_OUT:   o_cmd.load_out  = i_status.out_free;
            default: ;
        endcase
    end

endmodule

@@ hdl/frame_time_and_rate_statistics_top.sv @@
// Frame time and rate statistics monitor, top level.
// Frame end: execute, accumulate, divider start, divide, write-back and output states;
// divide waits on the 64-step mean divider (the rate divider runs beside it, 42 steps).
// Other actions: execute, then output. No new beat is taken until the result is loaded.
// Synchronous active-low reset restores all statistics and both registers at once.
`include "frame_time_and_rate_statistics_top_assert.svh"

module frame_time_and_rate_statistics_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ftrs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ftrs_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [ftrs_pkg::ACTION_W-1:0]     i_action,
    input  logic [ftrs_pkg::TIME_US_W-1:0]    i_time_us,
    input  logic [ftrs_pkg::TIME_MS_W-1:0]    i_time_ms,
    input  logic [ftrs_pkg::MEM_W-1:0]        i_free_mem_bytes,
    input  logic [ftrs_pkg::STACK_W-1:0]      i_stack_headroom_words,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [ftrs_pkg::RATE_W-1:0]       o_frames_per_second,
    output logic [ftrs_pkg::DUR_W-1:0]        o_mean_frame_us,
    output logic [ftrs_pkg::DUR_W-1:0]        o_min_frame_us,
    output logic [ftrs_pkg::DUR_W-1:0]        o_max_frame_us,
    output logic [ftrs_pkg::CNT_W-1:0]        o_frames_seen,
    output logic [ftrs_pkg::MEM_W-1:0]        o_mem_free_bytes,
    output logic [ftrs_pkg::MEM_W-1:0]        o_mem_low_bytes,
    output logic [ftrs_pkg::STACK_W-1:0]      o_stack_words,
    output logic [ftrs_pkg::TIME_MS_W-1:0]    o_uptime_ms
);
    import ftrs_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    ftrs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    ftrs_dp u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (w_cmd),
        .o_status               (w_status),
        .i_cfg_valid            (i_cfg_valid),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_action               (i_action),
        .i_time_us              (i_time_us),
        .i_time_ms              (i_time_ms),
        .i_free_mem_bytes       (i_free_mem_bytes),
        .i_stack_headroom_words (i_stack_headroom_words),
        .i_stall                (i_stall),
        .o_valid                (o_valid),
        .o_frames_per_second    (o_frames_per_second),
        .o_mean_frame_us        (o_mean_frame_us),
        .o_min_frame_us         (o_min_frame_us),
        .o_max_frame_us         (o_max_frame_us),
        .o_frames_seen          (o_frames_seen),
        .o_mem_free_bytes       (o_mem_free_bytes),
        .o_mem_low_bytes        (o_mem_low_bytes),
        .o_stack_words          (o_stack_words),
        .o_uptime_ms            (o_uptime_ms)
    );

    `FTRS_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "beat taken while busy")
    `FTRS_ASSERT_NOW(a_min_le_max, o_valid && (o_frames_seen != '0), o_min_frame_us <= o_max_frame_us, "min above max")
    `FTRS_ASSERT_NOW(a_mem_low_le_last, o_valid, o_mem_low_bytes <= o_mem_free_bytes, "low mark above last sample")

endmodule

@@ tb/ftrs_checker.sv @@
// Checker for the frame time and rate statistics block: snoops the register, event and
// result channels, predicts each result beat and compares it field by field.
// Depends on ftrs_pkg for widths, action codes, register indexes and reset values.
module ftrs_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [ftrs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ftrs_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_ev_valid,
    input  logic                           i_ev_stall,
    input  logic [ftrs_pkg::ACTION_W-1:0]  i_action,
    input  logic [ftrs_pkg::TIME_US_W-1:0] i_time_us,
    input  logic [ftrs_pkg::TIME_MS_W-1:0] i_time_ms,
    input  logic [ftrs_pkg::MEM_W-1:0]     i_free_mem_bytes,
    input  logic [ftrs_pkg::STACK_W-1:0]   i_stack_headroom_words,
    input  logic                           i_res_valid,
    input  logic                           i_res_stall,
    input  logic [ftrs_pkg::RATE_W-1:0]    i_frames_per_second,
    input  logic [ftrs_pkg::DUR_W-1:0]     i_mean_frame_us,
    input  logic [ftrs_pkg::DUR_W-1:0]     i_min_frame_us,
    input  logic [ftrs_pkg::DUR_W-1:0]     i_max_frame_us,
    input  logic [ftrs_pkg::CNT_W-1:0]     i_frames_seen,
    input  logic [ftrs_pkg::MEM_W-1:0]     i_mem_free_bytes,
    input  logic [ftrs_pkg::MEM_W-1:0]     i_mem_low_bytes,
    input  logic [ftrs_pkg::STACK_W-1:0]   i_stack_words,
    input  logic [ftrs_pkg::TIME_MS_W-1:0] i_uptime_ms,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import ftrs_pkg::*;

    typedef struct packed {
        logic [RATE_W-1:0]    fps;
        logic [DUR_W-1:0]     mean;
        logic [DUR_W-1:0]     min;
        logic [DUR_W-1:0]     max;
        logic [CNT_W-1:0]     frames;
        logic [MEM_W-1:0]     mem_free;
        logic [MEM_W-1:0]     mem_low;
        logic [STACK_W-1:0]   stack;
        logic [TIME_MS_W-1:0] uptime;
    } t_frame_metrics;

    logic [CFG_W-1:0]     cfg_window;
    logic [CFG_W-1:0]     cfg_period;
    logic [TIME_US_W-1:0] mark_us;
    logic [CNT_W-1:0]     frames_done;
    logic [SUM_W-1:0]     dur_total;
    logic [DUR_W-1:0]     dur_min;
    logic [DUR_W-1:0]     dur_max;
    logic [DUR_W-1:0]     dur_mean;
    logic [CNT_W-1:0]     win_count;
    logic [TIME_MS_W-1:0] win_origin;
    logic [RATE_W-1:0]    fps_now;
    logic [CFG_W-1:0]     since_sample;
    logic [MEM_W-1:0]     mem_recent;
    logic [MEM_W-1:0]     mem_floor;
    logic [STACK_W-1:0]   stack_recent;

    t_frame_metrics expected_metrics[$];
    t_frame_metrics want;
    int fail_count = 0;
    int checked = 0;
    int pending = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_checked    = checked;

    function t_frame_metrics advance_monitor(logic [ACTION_W-1:0] act,
                                             logic [TIME_US_W-1:0] us,
                                             logic [TIME_MS_W-1:0] ms,
                                             logic [MEM_W-1:0] mem,
                                             logic [STACK_W-1:0] stk);
        t_frame_metrics m;
        logic [TIME_US_W-1:0] diff;
        logic [DUR_W-1:0] dur;
        logic [TIME_MS_W-1:0] elapsed;
        logic [TIME_MS_W-1:0] span;
        logic [63:0] rate;
        case (act)
            ACT_BEGIN: begin
                mark_us = us;
            end
            ACT_END: begin
                dur = '0;
                if (us > mark_us) begin
                    diff = us - mark_us;
                    dur = diff[DUR_W-1:0];
                end
                frames_done = frames_done + 1'b1;
                dur_total = dur_total + {32'd0, dur};
                if (dur < dur_min) dur_min = dur;
                if (dur > dur_max) dur_max = dur;
                if (frames_done != '0) begin
                    rate = dur_total / {32'd0, frames_done};
                    dur_mean = rate[DUR_W-1:0];
                end
                win_count = win_count + 1'b1;
                if (win_origin == '0) win_origin = ms;
                elapsed = ms - win_origin;
                span = (cfg_window == '0) ? 32'd1 : {16'd0, cfg_window};
                if (elapsed >= span) begin
                    rate = ({32'd0, win_count} * 64'(MS_PER_S)) / {32'd0, elapsed};
                    fps_now = (rate > 64'hFFFF) ? '1 : rate[RATE_W-1:0];
                    win_count = '0;
                    win_origin = ms;
                end
                since_sample = since_sample + 1'b1;
                if (since_sample >= cfg_period) begin
                    since_sample = '0;
                    mem_recent = mem;
                    if (mem < mem_floor) mem_floor = mem;
                end
                if (since_sample == 16'd1) stack_recent = stk;
            end
            ACT_CLEAR: begin
                dur_min = '1;
                dur_max = '0;
                dur_total = '0;
                dur_mean = '0;
                frames_done = '0;
                win_count = '0;
                win_origin = '0;
                fps_now = '0;
                mem_floor = mem_recent;
            end
            default: ;
        endcase
        m.fps      = fps_now;
        m.mean     = dur_mean;
        m.min      = (dur_min == '1) ? '0 : dur_min;
        m.max      = dur_max;
        m.frames   = frames_done;
        m.mem_free = mem_recent;
        m.mem_low  = (mem_floor == '1) ? '0 : mem_floor;
        m.stack    = stack_recent;
        m.uptime   = ms;
        return m;
    endfunction

    function void check_field(string field, logic [63:0] exp_val, logic [63:0] got);
        if (got !== exp_val) begin
            $error("%s: expected %0h, got %0h", field, exp_val, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_window   = FPS_WINDOW_RST;
            cfg_period   = SAMPLE_PERIOD_RST;
            mark_us      = '0;
            frames_done  = '0;
            dur_total    = '0;
            dur_min      = '1;
            dur_max      = '0;
            dur_mean     = '0;
            win_count    = '0;
            win_origin   = '0;
            fps_now      = '0;
            since_sample = '0;
            mem_recent   = '0;
            mem_floor    = '1;
            stack_recent = '0;
            expected_metrics.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_FPS_WINDOW) cfg_window = i_cfg_data;
                else if (i_cfg_index == REG_SAMPLE_PERIOD) cfg_period = i_cfg_data;
            end
            if (i_ev_valid && !i_ev_stall) begin
                expected_metrics.push_back(advance_monitor(i_action, i_time_us, i_time_ms,
                    i_free_mem_bytes, i_stack_headroom_words));
            end
            if (i_res_valid && !i_res_stall) begin
                if (expected_metrics.size() == 0) begin
                    $error("result beat with no event waiting for it");
                    fail_count++;
                end else begin
                    want = expected_metrics.pop_front();
                    checked++;
                    check_field("frames_per_second", want.fps, i_frames_per_second);
                    check_field("mean_frame_us", want.mean, i_mean_frame_us);
                    check_field("min_frame_us", want.min, i_min_frame_us);
                    check_field("max_frame_us", want.max, i_max_frame_us);
                    check_field("frames_seen", want.frames, i_frames_seen);
                    check_field("mem_free_bytes", want.mem_free, i_mem_free_bytes);
                    check_field("mem_low_bytes", want.mem_low, i_mem_low_bytes);
                    check_field("stack_words", want.stack, i_stack_words);
                    check_field("uptime_ms", want.uptime, i_uptime_ms);
                end
            end
        end
        pending = expected_metrics.size();
    end

endmodule

@@ tb/tb_frame_time_and_rate_statistics_top.sv @@
// Testbench top for the frame time and rate statistics block: resets it, walks it through
// several register settings with directed and random frame events, and gives the verdict.
// Depends on ftrs_pkg, the block's top level and ftrs_checker.
module tb_frame_time_and_rate_statistics_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ftrs_pkg::*;

    localparam logic [ACTION_W-1:0]  ACT_SPARE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd3;
    localparam int                   LONG_HOLD    = 600;
    localparam int                   DRAIN_CYCLES = 80;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [ACTION_W-1:0]  i_action = '0;
    logic [TIME_US_W-1:0] i_time_us = '0;
    logic [TIME_MS_W-1:0] i_time_ms = '0;
    logic [MEM_W-1:0]     i_free_mem_bytes = '0;
    logic [STACK_W-1:0]   i_stack_headroom_words = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [RATE_W-1:0]    o_frames_per_second;
    logic [DUR_W-1:0]     o_mean_frame_us;
    logic [DUR_W-1:0]     o_min_frame_us;
    logic [DUR_W-1:0]     o_max_frame_us;
    logic [CNT_W-1:0]     o_frames_seen;
    logic [MEM_W-1:0]     o_mem_free_bytes;
    logic [MEM_W-1:0]     o_mem_low_bytes;
    logic [STACK_W-1:0]   o_stack_words;
    logic [TIME_MS_W-1:0] o_uptime_ms;

    int fail_count;
    int pending;
    int checked;

    int burst_left = 0;
    int holds_asked = 0;
    int holds_done = 0;
    int n_begin = 0;
    int n_end = 0;
    int n_clear = 0;
    int n_spare = 0;
    int n_settings = 1;
    logic [TIME_US_W-1:0] cur_us = '0;
    logic [TIME_MS_W-1:0] cur_ms = 32'd1;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    frame_time_and_rate_statistics_top dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_action               (i_action),
        .i_time_us              (i_time_us),
        .i_time_ms              (i_time_ms),
        .i_free_mem_bytes       (i_free_mem_bytes),
        .i_stack_headroom_words (i_stack_headroom_words),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_frames_per_second    (o_frames_per_second),
        .o_mean_frame_us        (o_mean_frame_us),
        .o_min_frame_us         (o_min_frame_us),
        .o_max_frame_us         (o_max_frame_us),
        .o_frames_seen          (o_frames_seen),
        .o_mem_free_bytes       (o_mem_free_bytes),
        .o_mem_low_bytes        (o_mem_low_bytes),
        .o_stack_words          (o_stack_words),
        .o_uptime_ms            (o_uptime_ms)
    );

    ftrs_checker u_checker (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_valid            (i_cfg_valid),
        .i_cfg_ready            (o_cfg_ready),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_ev_valid             (i_valid),
        .i_ev_stall             (o_stall),
        .i_action               (i_action),
        .i_time_us              (i_time_us),
        .i_time_ms              (i_time_ms),
        .i_free_mem_bytes       (i_free_mem_bytes),
        .i_stack_headroom_words (i_stack_headroom_words),
        .i_res_valid            (o_valid),
        .i_res_stall            (i_stall),
        .i_frames_per_second    (o_frames_per_second),
        .i_mean_frame_us        (o_mean_frame_us),
        .i_min_frame_us         (o_min_frame_us),
        .i_max_frame_us         (o_max_frame_us),
        .i_frames_seen          (o_frames_seen),
        .i_mem_free_bytes       (o_mem_free_bytes),
        .i_mem_low_bytes        (o_mem_low_bytes),
        .i_stack_words          (o_stack_words),
        .i_uptime_ms            (o_uptime_ms),
        .o_fail_count           (fail_count),
        .o_pending              (pending),
        .o_checked              (checked)
    );

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // result side: stall pattern of its own, plus long holds on request
    initial begin
        int mode;
        int span;
        int tick;
        int hold_left;
        tick = 0;
        hold_left = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 300);
            repeat (span) begin
                @(negedge i_clk);
                tick++;
                if (holds_done < holds_asked) begin
                    holds_done++;
                    hold_left = LONG_HOLD;
                end
                if (hold_left > 0) begin
                    hold_left--;
                    i_stall <= 1'b1;
                end else begin
                    case (mode)
                        0: i_stall <= 1'b0;
                        1: i_stall <= ($urandom_range(0, 3) == 0);
                        2: i_stall <= ($urandom_range(0, 9) < 6);
                        default: i_stall <= ((tick % 7) < 2);
                    endcase
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_event(input logic [ACTION_W-1:0] act, input logic [TIME_US_W-1:0] us,
                              input logic [TIME_MS_W-1:0] ms, input logic [MEM_W-1:0] mem,
                              input logic [STACK_W-1:0] stk);
        int gap;
        @(negedge i_clk);
        i_action               <= act;
        i_time_us              <= us;
        i_time_ms              <= ms;
        i_free_mem_bytes       <= mem;
        i_stack_headroom_words <= stk;
        i_valid                <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        case (act)
            ACT_BEGIN: n_begin++;
            ACT_END:   n_end++;
            ACT_CLEAR: n_clear++;
            default:   n_spare++;
        endcase
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 12);
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic step_clock(input int ms_max, input int zero_pml);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) cur_us = 48'({$urandom, $urandom});
        else cur_us = cur_us + $urandom_range(1, 40000);
        r = $urandom_range(0, 999);
        if (r < zero_pml) cur_ms = cur_ms;
        else if (r < 997) cur_ms = cur_ms + $urandom_range(1, ms_max);
        else if (r < 999) cur_ms = cur_ms + $urandom_range(1, 200000);
        else cur_ms = $urandom;
    endtask

    function automatic logic [MEM_W-1:0] pick_mem();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '1;
        if (r == 1) return 24'($urandom_range(0, 255));
        return 24'($urandom);
    endfunction

    task automatic run_random_phase(input logic [CFG_W-1:0] window, input logic [CFG_W-1:0] period,
                                    input int n, input int ms_max, input int zero_pml,
                                    input bit with_hold);
        int sent;
        int r;
        bit asked;
        logic [TIME_US_W-1:0] end_us;
        drain();
        write_reg(REG_FPS_WINDOW, window);
        write_reg(REG_SAMPLE_PERIOD, period);
        n_settings++;
        sent = 0;
        asked = 1'b0;
        while (sent < n) begin
            if (with_hold && !asked && sent >= n / 2) begin
                asked = 1'b1;
                holds_asked++;
            end
            r = $urandom_range(0, 99);
            if (r < 80) begin
                step_clock(ms_max, zero_pml);
                send_event(ACT_BEGIN, cur_us, cur_ms, pick_mem(), 16'($urandom));
                step_clock(ms_max, zero_pml);
                end_us = cur_us;
                if ($urandom_range(0, 19) == 0) end_us = cur_us - $urandom_range(0, 5000);
                send_event(ACT_END, end_us, cur_ms, pick_mem(), 16'($urandom));
                sent += 2;
            end else if (r < 88) begin
                step_clock(ms_max, zero_pml);
                send_event(ACT_END, cur_us, cur_ms, pick_mem(), 16'($urandom));
                sent++;
            end else if (r < 93) begin
                step_clock(ms_max, zero_pml);
                send_event(ACT_BEGIN, cur_us, cur_ms, pick_mem(), 16'($urandom));
                sent++;
            end else if (r < 96) begin
                send_event(ACT_CLEAR, 48'({$urandom, $urandom}), cur_ms, pick_mem(),
                           16'($urandom));
                sent++;
            end else begin
                send_event(ACT_SPARE, 48'({$urandom, $urandom}), cur_ms, pick_mem(),
                           16'($urandom));
            end
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: window 1000 ms, sample every 60 frames
        send_event(ACT_SPARE, '1, '1, '1, '1);
        send_event(ACT_BEGIN, 48'd1000, 32'd1, 24'h123456, 16'h0001);
        send_event(ACT_END, 48'd1250, 32'd2, 24'h00FF00, 16'h8000);
        send_event(ACT_BEGIN, 48'd2000, 32'd3, 24'h000000, 16'h0000);
        send_event(ACT_END, 48'd1500, 32'd4, 24'hFFFFFF, 16'hFFFF);
        send_event(ACT_BEGIN, '1, 32'd5, 24'h800000, 16'h7FFF);
        send_event(ACT_END, '1, 32'd5, 24'h7FFFFF, 16'h1234);
        send_event(ACT_BEGIN, '0, 32'd6, 24'h000001, 16'h0002);
        send_event(ACT_END, 48'h8765_4321_0FED, 32'd1002, 24'hABCDEF, 16'hA5A5);
        send_event(ACT_CLEAR, 48'h0000_0000_0000, 32'd1003, 24'h555555, 16'h5A5A);
        send_event(ACT_BEGIN, 48'd10, 32'd0, 24'h0F0F0F, 16'h0F0F);
        send_event(ACT_END, 48'd10 + 48'hFFFF_FFFF, 32'd0, 24'hF0F0F0, 16'hF0F0);
        send_event(ACT_END, 48'h0000_0002_0000_0000, 32'hFFFF_FFF0, 24'h333333, 16'h3333);
        send_event(ACT_END, 48'h0000_0002_0000_1000, 32'h0000_0400, 24'hCCCCCC, 16'hCCCC);
        send_event(ACT_SPARE, 48'h5555_5555_5555, 32'hAAAA_AAAA, 24'h000000, 16'h0000);

        run_random_phase(16'd0, 16'd0, 220, 1, 996, 1'b0);
        run_random_phase(16'd1, 16'd1, 145, 3, 500, 1'b1);
        drain();
        write_reg(REG_SPARE, 16'hA5A5);
        run_random_phase(16'hFFFF, 16'hFFFF, 145, 5000, 300, 1'b0);
        run_random_phase(FPS_WINDOW_RST, SAMPLE_PERIOD_RST, 145, 40, 400, 1'b1);
        run_random_phase(16'($urandom_range(2, 50)), 16'($urandom_range(2, 10)), 145, 10, 500,
                         1'b0);
        run_random_phase(16'd2, 16'd3, 145, 2, 600, 1'b0);

        drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Covered %0d frame begins, %0d frame ends, %0d clears, %0d unused-code beats",
                 n_begin, n_end, n_clear, n_spare);
        $display("%0d result beats checked over %0d register settings", checked, n_settings);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
